### sv/kiss_random_generator_top_defines.svh
// Assertion macros for the KISS random generator.
`ifndef KISS_RANDOM_GENERATOR_TOP_DEFINES_SVH
`define KISS_RANDOM_GENERATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define KRG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("krg assertion failed");
`define KRG_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("krg forbidden condition seen");
`else
`define KRG_ASSERT(lbl, clk, rst_n, prop)
`define KRG_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### sv/krg_pkg.sv
`default_nettype none

package krg_pkg;

    localparam logic [1:0] KIND_W32_G64 = 2'd0;
    localparam logic [1:0] KIND_W64     = 2'd1;
    localparam logic [1:0] KIND_W32_G32 = 2'd2;
    localparam logic [1:0] KIND_RESEED  = 2'd3;

    localparam logic [31:0] LCG32_MUL   = 32'd314527869;
    localparam logic [31:0] LCG32_ADD   = 32'd1234567;
    localparam logic [31:0] MWC_A_MUL   = 32'd4294584393;
    localparam logic [31:0] MWC_B_MUL   = 32'd4246477509;
    localparam logic [63:0] LCG64_MUL   = 64'd1490024343005336237;
    localparam logic [63:0] LCG64_ADD   = 64'd123456789;
    localparam logic [31:0] CARRY_LIMIT = 32'd698769068;
    localparam logic [31:0] XS32_FIX    = 32'd11;
    localparam logic [63:0] XS64_FIX    = 64'd13;
    localparam logic [31:0] CARRY_A_FIX = 32'd17;
    localparam logic [31:0] CARRY_B_FIX = 32'd19;

    localparam logic [31:0] RST_LCG32       = 32'd123456789;
    localparam logic [31:0] RST_XS32        = 32'd987654321;
    localparam logic [31:0] RST_MWC32_VALUE = 32'd43219876;
    localparam logic [31:0] RST_MWC32_CARRY = 32'd6543217;
    localparam logic [63:0] RST_LCG64       = 64'd123456789123;
    localparam logic [63:0] RST_XS64        = 64'd987654321987;
    localparam logic [31:0] RST_MWC_A_VALUE = 32'd43219876;
    localparam logic [31:0] RST_MWC_A_CARRY = 32'd6543217;
    localparam logic [31:0] RST_MWC_B_VALUE = 32'd21987643;
    localparam logic [31:0] RST_MWC_B_CARRY = 32'd1732654;

    // one multiply-accumulate request: (a*b, optionally shifted up 32) + c
    typedef struct packed {
        logic        en;
        logic        shift;
        logic [31:0] a;
        logic [31:0] b;
        logic [63:0] c;
    } mac_op_t;

endpackage

`default_nettype wire

### sv/krg_mac.sv
`default_nettype none

module krg_mac
    import krg_pkg::*;
(
    input  wire logic        clk,
    input  wire mac_op_t     op,
    output logic [63:0]      result
);

    logic [63:0] prod;
    logic [63:0] term;
    logic [63:0] result_reg;
    logic [63:0] result_next;

    assign prod        = {32'd0, op.a} * {32'd0, op.b};
    assign term        = op.shift ? {prod[31:0], 32'd0} : prod;
    assign result_next = term + op.c;

    always_ff @(posedge clk)
    begin
        if (op.en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

### sv/kiss_random_generator_top.sv
// KISS random generator, 32-bit and 64-bit states.
// Request channel: req_valid/req_stall with kind and seed. kind selects a
// 32-bit word from the 64-bit state, a 64-bit word, a 32-bit word from the
// 32-bit state, or a reseed from seed. Response channel: rsp_valid/rsp_stall
// with value; a reseed produces no response transaction.
// One request is worked at a time; req_stall is high while it runs. All
// multiplies go through one 32x32 multiply-accumulate unit, one product per
// cycle. Each request runs these steps:
//   32-bit generator word: LCG product, MWC product, write-back, finish
//   64-bit generator: LCG partial products, MWC A product, MWC B product and
//   write-back for the 64-bit word only, finish; reseed: square, cube,
//   value, remainder reduction, 108 32-bit generator steps and a fix step.
// A new request is taken in the idle cycle right after the work ends, even
// while the previous response still waits in the output register.
// If the receiver stalls and the output register is full, the block holds its
// finished word until the register frees.
// Reset (rst_n low, asynchronous) loads the fixed seed state and idles.
`default_nettype none
`include "kiss_random_generator_top_defines.svh"

module kiss_random_generator_top
    import krg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] seed,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [63:0]      value
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_R_SQ    = 5'd1;
    localparam logic [4:0] S_R_CUBE  = 5'd2;
    localparam logic [4:0] S_R_VAL   = 5'd3;
    localparam logic [4:0] S_R_MOD   = 5'd4;
    localparam logic [4:0] S_R_FIX   = 5'd5;
    localparam logic [4:0] S_G32_LCG = 5'd6;
    localparam logic [4:0] S_G32_MWC = 5'd7;
    localparam logic [4:0] S_G32_WB  = 5'd8;
    localparam logic [4:0] S_G32_FIN = 5'd9;
    localparam logic [4:0] S_G64_L0  = 5'd10;
    localparam logic [4:0] S_G64_L1  = 5'd11;
    localparam logic [4:0] S_G64_L2  = 5'd12;
    localparam logic [4:0] S_G64_MA  = 5'd13;
    localparam logic [4:0] S_G64_MB  = 5'd14;
    localparam logic [4:0] S_G64_WB  = 5'd15;
    localparam logic [4:0] S_G64_FIN = 5'd16;

    localparam logic [6:0] WARMUP_STEPS = 7'd100;
    localparam logic [6:0] LAST_STEP    = 7'd107;

    function automatic logic [31:0] xs32_step(input logic [31:0] x);
        logic [31:0] t;
        t = x ^ (x << 5);
        t = t ^ (t >> 7);
        t = t ^ (t << 22);
        return t;
    endfunction

    function automatic logic [63:0] xs64_step(input logic [63:0] x);
        logic [63:0] t;
        t = x ^ (x << 21);
        t = t ^ (t >> 17);
        t = t ^ (t << 30);
        return t;
    endfunction

    logic [4:0]  state_reg, state_next;
    logic [1:0]  kind_reg, kind_next;
    logic        reseed_reg, reseed_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        rsp_valid_reg, rsp_valid_next;

    logic [31:0] lcg32_reg, lcg32_next;
    logic [31:0] xs32_reg, xs32_next;
    logic [31:0] mwc32_value_reg, mwc32_value_next;
    logic [31:0] mwc32_carry_reg, mwc32_carry_next;
    logic [63:0] lcg64_reg, lcg64_next;
    logic [63:0] xs64_reg, xs64_next;
    logic [31:0] mwc_a_value_reg, mwc_a_value_next;
    logic [31:0] mwc_a_carry_reg, mwc_a_carry_next;
    logic [31:0] mwc_b_value_reg, mwc_b_value_next;
    logic [31:0] mwc_b_carry_reg, mwc_b_carry_next;

    logic [31:0] seed_reg, seed_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] value_reg, value_next;

    mac_op_t     mac_op;
    logic [63:0] mac;
    logic        rsp_free;
    logic        rsp_load;
    logic [31:0] word32;
    logic [31:0] word32_g64;
    logic [63:0] word64;
    logic [31:0] sq_plus;
    logic [6:0]  slot_full;
    logic [2:0]  slot;

    krg_mac u_mac
    (
        .clk    (clk),
        .op     (mac_op),
        .result (mac)
    );

    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign word32     = lcg32_reg + xs32_reg + mwc32_value_reg;
    assign word32_g64 = lcg64_reg[63:32] + xs64_reg[31:0] + mwc_a_value_reg;
    assign word64     = lcg64_reg + xs64_reg + {mwc_b_value_reg, mwc_a_value_reg};
    assign sq_plus    = mac[31:0] + 32'd7;
    assign slot_full  = cnt_reg - WARMUP_STEPS;
    assign slot       = slot_full[2:0];

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        reseed_next      = reseed_reg;
        cnt_next         = cnt_reg;
        lcg32_next       = lcg32_reg;
        xs32_next        = xs32_reg;
        mwc32_value_next = mwc32_value_reg;
        mwc32_carry_next = mwc32_carry_reg;
        lcg64_next       = lcg64_reg;
        xs64_next        = xs64_reg;
        mwc_a_value_next = mwc_a_value_reg;
        mwc_a_carry_next = mwc_a_carry_reg;
        mwc_b_value_next = mwc_b_value_reg;
        mwc_b_carry_next = mwc_b_carry_reg;
        seed_next        = seed_reg;
        rem_next         = rem_reg;
        value_next       = value_reg;
        rsp_load         = 1'b0;
        mac_op           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next   = kind;
                    seed_next   = seed;
                    reseed_next = 1'b0;
                    case (kind)
                        KIND_W32_G64: state_next = S_G64_L0;
                        KIND_W64:     state_next = S_G64_L0;
                        KIND_W32_G32: state_next = S_G32_LCG;
                        default:
                        begin
                            reseed_next = 1'b1;
                            lcg32_next  = seed;
                            rem_next    = seed ^ (seed >> 11);
                            state_next  = S_R_SQ;
                        end
                    endcase
                end
            end
            S_R_SQ:
            begin
                mac_op     = '{en: 1'b1, shift: 1'b0, a: seed_reg, b: seed_reg, c: 64'd0};
                state_next = S_R_CUBE;
            end
            S_R_CUBE:
            begin
                xs32_next  = (sq_plus == 32'd0) ? XS32_FIX : sq_plus;
                mac_op     = '{en: 1'b1, shift: 1'b0, a: mac[31:0], b: seed_reg, c: 64'd0};
                state_next = S_R_VAL;
            end
            S_R_VAL:
            begin
                mwc32_value_next = mac[31:0];
                state_next       = S_R_MOD;
            end
            S_R_MOD:
            begin
                if (rem_reg >= CARRY_LIMIT)
                begin
                    rem_next = rem_reg - CARRY_LIMIT;
                end
                else
                begin
                    mwc32_carry_next = rem_reg + 32'd1;
                    cnt_next         = 7'd0;
                    state_next       = S_G32_LCG;
                end
            end
            S_R_FIX:
            begin
                if (xs64_reg == 64'd0)
                begin
                    xs64_next = XS64_FIX;
                end
                if (mwc_a_carry_reg > CARRY_LIMIT)
                begin
                    mwc_a_carry_next = CARRY_A_FIX;
                end
                if (mwc_b_carry_reg > CARRY_LIMIT)
                begin
                    mwc_b_carry_next = CARRY_B_FIX;
                end
                reseed_next = 1'b0;
                state_next  = S_IDLE;
            end
            S_G32_LCG:
            begin
                xs32_next  = xs32_step(xs32_reg);
                mac_op     = '{en: 1'b1, shift: 1'b0, a: LCG32_MUL, b: lcg32_reg,
                               c: {32'd0, LCG32_ADD}};
                state_next = S_G32_MWC;
            end
            S_G32_MWC:
            begin
                lcg32_next = mac[31:0];
                mac_op     = '{en: 1'b1, shift: 1'b0, a: MWC_A_MUL, b: mwc32_value_reg,
                               c: {32'd0, mwc32_carry_reg}};
                state_next = S_G32_WB;
            end
            S_G32_WB:
            begin
                mwc32_value_next = mac[31:0];
                mwc32_carry_next = mac[63:32];
                state_next       = S_G32_FIN;
            end
            S_G32_FIN:
            begin
                if (reseed_reg)
                begin
                    if (cnt_reg >= WARMUP_STEPS)
                    begin
                        case (slot)
                            3'd0:    lcg64_next[63:32] = word32;
                            3'd1:    xs64_next[63:32]  = word32;
                            3'd2:    mwc_a_value_next  = word32;
                            3'd3:    mwc_a_carry_next  = word32;
                            3'd4:    mwc_b_value_next  = word32;
                            3'd5:    mwc_b_carry_next  = word32;
                            3'd6:    lcg64_next[31:0]  = word32;
                            default: xs64_next[31:0]   = word32;
                        endcase
                    end
                    if (cnt_reg == LAST_STEP)
                    begin
                        state_next = S_R_FIX;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 7'd1;
                        state_next = S_G32_LCG;
                    end
                end
                else if (rsp_free)
                begin
                    rsp_load   = 1'b1;
                    value_next = {32'd0, word32};
                    state_next = S_IDLE;
                end
            end
            S_G64_L0:
            begin
                xs64_next  = xs64_step(xs64_reg);
                mac_op     = '{en: 1'b1, shift: 1'b0, a: LCG64_MUL[31:0],
                               b: lcg64_reg[31:0], c: LCG64_ADD};
                state_next = S_G64_L1;
            end
            S_G64_L1:
            begin
                mac_op     = '{en: 1'b1, shift: 1'b1, a: LCG64_MUL[63:32],
                               b: lcg64_reg[31:0], c: mac};
                state_next = S_G64_L2;
            end
            S_G64_L2:
            begin
                mac_op     = '{en: 1'b1, shift: 1'b1, a: LCG64_MUL[31:0],
                               b: lcg64_reg[63:32], c: mac};
                state_next = S_G64_MA;
            end
            S_G64_MA:
            begin
                lcg64_next = mac;
                mac_op     = '{en: 1'b1, shift: 1'b0, a: MWC_A_MUL, b: mwc_a_value_reg,
                               c: {32'd0, mwc_a_carry_reg}};
                state_next = S_G64_MB;
            end
            S_G64_MB:
            begin
                mwc_a_value_next = mac[31:0];
                mwc_a_carry_next = mac[63:32];
                if (kind_reg == KIND_W64)
                begin
                    mac_op     = '{en: 1'b1, shift: 1'b0, a: MWC_B_MUL, b: mwc_b_value_reg,
                                   c: {32'd0, mwc_b_carry_reg}};
                    state_next = S_G64_WB;
                end
                else
                begin
                    state_next = S_G64_FIN;
                end
            end
            S_G64_WB:
            begin
                mwc_b_value_next = mac[31:0];
                mwc_b_carry_next = mac[63:32];
                state_next       = S_G64_FIN;
            end
            S_G64_FIN:
            begin
                if (rsp_free)
                begin
                    rsp_load   = 1'b1;
                    value_next = (kind_reg == KIND_W64) ? word64 : {32'd0, word32_g64};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            kind_reg        <= KIND_W32_G64;
            reseed_reg      <= 1'b0;
            cnt_reg         <= 7'd0;
            rsp_valid_reg   <= 1'b0;
            lcg32_reg       <= RST_LCG32;
            xs32_reg        <= RST_XS32;
            mwc32_value_reg <= RST_MWC32_VALUE;
            mwc32_carry_reg <= RST_MWC32_CARRY;
            lcg64_reg       <= RST_LCG64;
            xs64_reg        <= RST_XS64;
            mwc_a_value_reg <= RST_MWC_A_VALUE;
            mwc_a_carry_reg <= RST_MWC_A_CARRY;
            mwc_b_value_reg <= RST_MWC_B_VALUE;
            mwc_b_carry_reg <= RST_MWC_B_CARRY;
        end
        else
        begin
            state_reg       <= state_next;
            kind_reg        <= kind_next;
            reseed_reg      <= reseed_next;
            cnt_reg         <= cnt_next;
            rsp_valid_reg   <= rsp_valid_next;
            lcg32_reg       <= lcg32_next;
            xs32_reg        <= xs32_next;
            mwc32_value_reg <= mwc32_value_next;
            mwc32_carry_reg <= mwc32_carry_next;
            lcg64_reg       <= lcg64_next;
            xs64_reg        <= xs64_next;
            mwc_a_value_reg <= mwc_a_value_next;
            mwc_a_carry_reg <= mwc_a_carry_next;
            mwc_b_value_reg <= mwc_b_value_next;
            mwc_b_carry_reg <= mwc_b_carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg  <= seed_next;
        rem_reg   <= rem_next;
        value_reg <= value_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign value     = value_reg;

    `KRG_ASSERT(a_busy_after_accept, clk, rst_n, (req_valid && !req_stall) |=> req_stall)
    `KRG_NEVER(a_no_reseed_response, clk, rst_n, reseed_reg && rsp_load)
    `KRG_ASSERT(a_carry_init_range, clk, rst_n, (state_reg == S_R_MOD && rem_reg < CARRY_LIMIT) |=> (mwc32_carry_reg != 32'd0 && mwc32_carry_reg <= CARRY_LIMIT))
    `KRG_ASSERT(a_reseed_fixed, clk, rst_n, (state_reg == S_R_FIX) |=> (xs64_reg != 64'd0 && mwc_a_carry_reg <= CARRY_LIMIT && mwc_b_carry_reg <= CARRY_LIMIT))

endmodule

`default_nettype wire

### dv/kiss_random_generator_top_tb.sv
`default_nettype none

module kiss_random_generator_top_tb;
    import krg_pkg::*;

    localparam logic [31:0] SM_LCG_MUL    = 32'd314527869;
    localparam logic [31:0] SM_LCG_ADD    = 32'd1234567;
    localparam logic [63:0] MWC_MUL_A     = 64'd4294584393;
    localparam logic [63:0] MWC_MUL_B     = 64'd4246477509;
    localparam logic [63:0] WIDE_LCG_MUL  = 64'd1490024343005336237;
    localparam logic [63:0] WIDE_LCG_ADD  = 64'd123456789;
    localparam logic [31:0] CARRY_CAP     = 32'd698769068;
    localparam logic [31:0] SM_XS_FIX     = 32'd11;
    localparam logic [63:0] WIDE_XS_FIX   = 64'd13;
    localparam logic [31:0] CAR_A_FIX     = 32'd17;
    localparam logic [31:0] CAR_B_FIX     = 32'd19;
    localparam int          WARMUP_WORDS  = 100;
    localparam int          DIRECTED_ROWS = 23;
    localparam int          RANDOM_ITEMS  = 1130;
    localparam int          QUIET_ITEMS   = 150;
    localparam int          SETTLE_CYCLES = 500;
    localparam int          CYCLE_LIMIT   = 1500000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] seed;
        logic        hi_known;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [1:0]  kind = KIND_W32_G32;
    logic [31:0] seed = 32'd0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [63:0] value;

    // predicted generator state
    logic [31:0] small_lcg, small_xs, small_mv, small_mc;
    logic [63:0] wide_lcg, wide_xs;
    logic [31:0] pa_val, pa_car, pb_val, pb_car;

    logic [63:0] expected_values[$];
    logic [63:0] want;
    stim_row_t   dir_rows [DIRECTED_ROWS];
    logic [31:0] zero_xs_seed;
    int          errors = 0;
    int          words_checked = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    int          kind_count [4];
    bit          drain_phase = 1'b0;

    kiss_random_generator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .kind      (kind),
        .seed      (seed),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .value     (value)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] mwc_product(input logic [31:0] v, input logic [31:0] c,
                                                input logic [63:0] mul);
        return mul * {32'd0, v} + {32'd0, c};
    endfunction

    function automatic logic [31:0] small_word();
        logic [63:0] t;
        small_lcg = SM_LCG_MUL * small_lcg + SM_LCG_ADD;
        small_xs = small_xs ^ (small_xs << 5);
        small_xs = small_xs ^ (small_xs >> 7);
        small_xs = small_xs ^ (small_xs << 22);
        t = mwc_product(small_mv, small_mc, MWC_MUL_A);
        small_mc = t[63:32];
        small_mv = t[31:0];
        return small_lcg + small_xs + small_mv;
    endfunction

    function automatic void wide_advance();
        logic [63:0] t;
        wide_lcg = WIDE_LCG_MUL * wide_lcg + WIDE_LCG_ADD;
        wide_xs = wide_xs ^ (wide_xs << 21);
        wide_xs = wide_xs ^ (wide_xs >> 17);
        wide_xs = wide_xs ^ (wide_xs << 30);
        t = mwc_product(pa_val, pa_car, MWC_MUL_A);
        pa_car = t[63:32];
        pa_val = t[31:0];
    endfunction

    function automatic logic [63:0] predict_value(input logic [1:0] k);
        logic [63:0] t;
        logic [31:0] w;
        case (k)
            KIND_W32_G64:
            begin
                wide_advance();
                w = wide_lcg[63:32] + wide_xs[31:0] + pa_val;
                return {32'd0, w};
            end
            KIND_W64:
            begin
                wide_advance();
                t = mwc_product(pb_val, pb_car, MWC_MUL_B);
                pb_car = t[63:32];
                pb_val = t[31:0];
                return wide_lcg + wide_xs + {32'd0, pa_val} + {pb_val, 32'd0};
            end
            default:
            begin
                w = small_word();
                return {32'd0, w};
            end
        endcase
    endfunction

    function automatic void apply_seed(input logic [31:0] s);
        logic [31:0] sq;
        logic [31:0] w [8];
        sq = s * s;
        small_lcg = s;
        small_xs = sq + 32'd7;
        if (small_xs == 32'd0)
            small_xs = SM_XS_FIX;
        small_mv = sq * s;
        small_mc = (s ^ (s >> 11)) % CARRY_CAP + 32'd1;
        for (int i = 0; i < WARMUP_WORDS; i++)
            void'(small_word());
        for (int i = 0; i < 8; i++)
            w[i] = small_word();
        wide_lcg = {w[0], w[6]};
        wide_xs = {w[1], w[7]};
        pa_val = w[2];
        pa_car = w[3];
        pb_val = w[4];
        pb_car = w[5];
        if (wide_xs == 64'd0)
            wide_xs = WIDE_XS_FIX;
        if (pa_car > CARRY_CAP)
            pa_car = CAR_A_FIX;
        if (pb_car > CARRY_CAP)
            pb_car = CAR_B_FIX;
    endfunction

    // one request transaction; prediction happens at the accepting edge
    task automatic send_request(input logic [1:0] k, input logic [31:0] s, input int gap,
                                input bit hi_known);
        logic [63:0] p;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        kind <= k;
        seed <= s;
        do
            @(posedge clk);
        while (req_stall);
        kind_count[k]++;
        if (k == KIND_RESEED)
            apply_seed(s);
        else
        begin
            p = predict_value(k);
            if (hi_known)
                p[63:32] = 32'h0;
            expected_values.push_back(p);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (!drain_phase && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 10);
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_values.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction, expected none, actual %h", $time, value);
            end
            else
            begin
                want = expected_values.pop_front();
                words_checked++;
                if (value !== want)
                begin
                    errors++;
                    $display("%0t: value mismatch, expected %h, actual %h", $time, want, value);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] tmp;
        logic [1:0]  k;
        logic [31:0] s;
        int          gap;
        int          pick;

        for (int i = 0; i < 4; i++)
            kind_count[i] = 0;

        small_lcg = 32'd123456789;
        small_xs = 32'd987654321;
        small_mv = 32'd43219876;
        small_mc = 32'd6543217;
        wide_lcg = 64'd123456789123;
        wide_xs = 64'd987654321987;
        pa_val = 32'd43219876;
        pa_car = 32'd6543217;
        pb_val = 32'd21987643;
        pb_car = 32'd1732654;

        // square root of -7 mod 2^32: a seed whose xorshift seed word wraps to zero
        zero_xs_seed = 32'd1;
        for (int b = 3; b < 32; b++)
        begin
            tmp = zero_xs_seed * zero_xs_seed + 32'd7;
            if (tmp[b])
                zero_xs_seed = zero_xs_seed + (32'd1 << (b - 1));
        end

        dir_rows[0]  = {KIND_W32_G32, 32'hFFFF_FFFF, 1'b1};
        dir_rows[1]  = {KIND_W32_G64, 32'h0000_0000, 1'b1};
        dir_rows[2]  = {KIND_W64,     32'h0000_0000, 1'b0};
        dir_rows[3]  = {KIND_W64,     32'hFFFF_FFFF, 1'b0};
        dir_rows[4]  = {KIND_RESEED,  32'h0000_0000, 1'b0};
        dir_rows[5]  = {KIND_W32_G32, 32'h0000_0000, 1'b1};
        dir_rows[6]  = {KIND_W32_G64, 32'h0000_0000, 1'b1};
        dir_rows[7]  = {KIND_W64,     32'h0000_0000, 1'b0};
        dir_rows[8]  = {KIND_RESEED,  32'hFFFF_FFFF, 1'b0};
        dir_rows[9]  = {KIND_W64,     32'h0000_0000, 1'b0};
        dir_rows[10] = {KIND_W32_G32, 32'h0000_0000, 1'b1};
        dir_rows[11] = {KIND_RESEED,  zero_xs_seed,  1'b0};
        dir_rows[12] = {KIND_W32_G32, 32'h0000_0000, 1'b1};
        dir_rows[13] = {KIND_W32_G64, 32'h0000_0000, 1'b1};
        dir_rows[14] = {KIND_RESEED,  -zero_xs_seed, 1'b0};
        dir_rows[15] = {KIND_W64,     32'h0000_0000, 1'b0};
        dir_rows[16] = {KIND_RESEED,  32'h0000_0001, 1'b0};
        dir_rows[17] = {KIND_W32_G64, 32'h0000_0000, 1'b1};
        dir_rows[18] = {KIND_RESEED,  32'h8000_0000, 1'b0};
        dir_rows[19] = {KIND_W64,     32'hFFFF_FFFF, 1'b0};
        dir_rows[20] = {KIND_W32_G32, 32'hFFFF_FFFF, 1'b1};
        dir_rows[21] = {KIND_RESEED,  CARRY_CAP,     1'b0};
        dir_rows[22] = {KIND_W32_G64, 32'h0000_0000, 1'b1};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(dir_rows[i].kind, dir_rows[i].seed, (i % 3 == 2) ? 2 : 0,
                         dir_rows[i].hi_known);
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                drain_phase = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                k = KIND_RESEED;
                case ($urandom_range(0, 9))
                    0: s = 32'h0000_0000;
                    1: s = 32'hFFFF_FFFF;
                    2: s = zero_xs_seed;
                    3: s = -zero_xs_seed;
                    default: s = $urandom;
                endcase
            end
            else
            begin
                k = 2'($urandom_range(0, 2));
                s = $urandom;
            end
            if (!drain_phase && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 11);
            else
                gap = 0;
            send_request(k, s, gap, 1'b0);
        end
        req_valid <= 1'b0;

        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run: %0d requests (%0d/%0d/%0d word kinds, %0d reseeds), %0d words checked",
                 kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3],
                 kind_count[KIND_W32_G64], kind_count[KIND_W64], kind_count[KIND_W32_G32],
                 kind_count[KIND_RESEED], words_checked);
        $display("Mismatches: %0d", errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+sv
sv/krg_pkg.sv
sv/krg_mac.sv
sv/kiss_random_generator_top.sv
dv/kiss_random_generator_top_tb.sv
